// ----- hw/rtl/mrct_pkg.sv -----
`timescale 1ns / 1ps
// Shared package for the memory range change tracker.
// Holds default parameter values, command codes and controller/datapath structs.
package mrct_pkg;

	localparam int ADDR_BITS_DEF    = 32;
	localparam int PAGE_SHIFT_DEF   = 16;
	localparam int RECORD_DEPTH_DEF = 4096;
	localparam int FIELD_ADDR_W     = 32;
	localparam int REV_W            = 64;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_QUERY = 2'd1,
		CMD_STAMP = 2'd2,
		CMD_CHECK = 2'd3
	} cmd_code_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic clr_step;
		logic log_write;
		logic stamp_step;
		logic pscan_step;
		logic rscan_start;
		logic rscan_step;
		logic out_load;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_code_t code;
		logic      invalid;
		logic      clr_last;
		logic      page_last;
		logic      rec_last;
		logic      rev_match;
		logic      count_zero;
	} dp_stat_t;

endpackage

// ----- hw/rtl/memory_range_change_tracker.sv -----
`timescale 1ns / 1ps
// Top level of the memory range change tracker.
// Instantiates mrct_ctrl and mrct_datapath; uses mrct_pkg.
//
// Usage: each input word carries one command on a byte range (note write, revision
// query, take stamp, check changed). Both channels use valid/ready; a word moves
// when valid and ready are high at a rising edge. A note write gives no result word;
// every other command gives exactly one result word.
// Steps after the input word is accepted: a query or stamp walks every page in the
// range, then presents its result. A check walks the pages the same way and, when
// the page revision differs from the caller's stamp and the ring holds records, also
// scans every logged record (up to RECORD_DEPTH) before its result is presented.
// An invalid range skips the walk and presents its result, unless it is a write. A
// write gives no result; the next word is accepted once it has stamped its pages.
// The page walk through the revision memory and the record scan through the record
// ring run one after the other; one item is worked on at a time.
// After reset the block clears all 2^(ADDR_BITS-PAGE_SHIFT) entries of the page
// revision memory (65536 by default), one entry per cycle; in_ready stays low until
// it finishes. The record ring is not cleared.
// The result sits in an output register, so a new word is taken while an earlier
// result waits; if the receiver stalls, the next result waits until it drains.
module memory_range_change_tracker #(
	parameter int ADDR_BITS    = mrct_pkg::ADDR_BITS_DEF,
	parameter int PAGE_SHIFT   = mrct_pkg::PAGE_SHIFT_DEF,
	parameter int RECORD_DEPTH = mrct_pkg::RECORD_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        cmd,
	input  logic [mrct_pkg::FIELD_ADDR_W-1:0] address,
	input  logic [mrct_pkg::FIELD_ADDR_W-1:0] byte_count,
	input  logic [mrct_pkg::REV_W-1:0]        stamp_page_revision,
	input  logic [mrct_pkg::REV_W-1:0]        stamp_write_epoch,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              changed,
	output logic [mrct_pkg::REV_W-1:0]        page_revision,
	output logic [mrct_pkg::REV_W-1:0]        write_epoch
);

	mrct_pkg::ctl_cmd_t ctl;
	mrct_pkg::dp_stat_t stat;

	// The controller owns the handshakes and sequencing.
	mrct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl),
		.stat      (stat)
	);

	// The datapath holds all tracking state and the result register.
	mrct_datapath #(
		.ADDR_BITS    (ADDR_BITS),
		.PAGE_SHIFT   (PAGE_SHIFT),
		.RECORD_DEPTH (RECORD_DEPTH)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.ctl                 (ctl),
		.stat                (stat),
		.cmd                 (cmd),
		.address             (address),
		.byte_count          (byte_count),
		.stamp_page_revision (stamp_page_revision),
		.stamp_write_epoch   (stamp_write_epoch),
		.changed             (changed),
		.page_revision       (page_revision),
		.write_epoch         (write_epoch)
	);

`ifndef ASSERT_OFF
	// One item at a time: the cycle after a word is taken, no other is taken.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// A result is never formed in the cycle right after acceptance.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !ctl.out_load)
		else $error("result formed too early");

	// Loading the result register always presents a result next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |=> out_valid)
		else $error("loaded result not presented");
`endif

endmodule

// ----- hw/rtl/mrct_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the range change tracker: page revision memory, write record ring,
// epoch counter, scan accumulators and the result register. Uses mrct_pkg.
module mrct_datapath #(
	parameter int ADDR_BITS    = mrct_pkg::ADDR_BITS_DEF,
	parameter int PAGE_SHIFT   = mrct_pkg::PAGE_SHIFT_DEF,
	parameter int RECORD_DEPTH = mrct_pkg::RECORD_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mrct_pkg::ctl_cmd_t                ctl,
	output mrct_pkg::dp_stat_t                stat,
	input  logic [1:0]                        cmd,
	input  logic [mrct_pkg::FIELD_ADDR_W-1:0] address,
	input  logic [mrct_pkg::FIELD_ADDR_W-1:0] byte_count,
	input  logic [mrct_pkg::REV_W-1:0]        stamp_page_revision,
	input  logic [mrct_pkg::REV_W-1:0]        stamp_write_epoch,
	output logic                              changed,
	output logic [mrct_pkg::REV_W-1:0]        page_revision,
	output logic [mrct_pkg::REV_W-1:0]        write_epoch
);

	localparam int PW = ADDR_BITS - PAGE_SHIFT;
	localparam int PAGES = 2 ** PW;
	localparam int HW = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
	localparam int CW = $clog2(RECORD_DEPTH + 1);
	localparam int RW = mrct_pkg::REV_W;

	typedef struct packed {
		logic [RW-1:0]        rev;
		logic [ADDR_BITS-1:0] first;
		logic [ADDR_BITS-1:0] last;
	} rec_t;

	logic [RW-1:0]  page_mem [PAGES];
	rec_t           rec_mem [RECORD_DEPTH];

	mrct_pkg::cmd_code_t  code_q;
	logic                 invalid_q;
	logic [ADDR_BITS-1:0] start_q, last_q;
	logic [RW-1:0]        srev_q, sep_q, acc_q, epoch_q;
	logic [PW-1:0]        p_q, lp_q, clr_q;
	logic [HW-1:0]        head_q, k_q;
	logic [CW-1:0]        count_q, i_q;
	logic                 hit_q;
	logic                 pacc_s1, racc_s1, rfirst_s1;
	logic [RW-1:0]        page_rd_s1;
	rec_t                 rec_rd_s1;

	logic [ADDR_BITS-1:0] in_start, in_bytes;
	logic [ADDR_BITS:0]   in_sum;
	logic [ADDR_BITS-1:0] in_last;
	logic [CW:0]          oldest_w;
	logic [HW-1:0]        oldest;
	logic                 page_we;
	logic [PW-1:0]        page_wa;
	logic [RW-1:0]        page_wd;
	logic                 rec_hit;

	assign in_start = ADDR_BITS'(address);
	assign in_bytes = ADDR_BITS'(byte_count);
	assign in_sum   = {1'b0, in_start} + {1'b0, in_bytes} - (ADDR_BITS + 1)'(1);
	assign in_last  = in_sum[ADDR_BITS] ? '1 : in_sum[ADDR_BITS-1:0];

	always_comb begin
		oldest_w = (CW + 1)'(head_q) + (CW + 1)'(RECORD_DEPTH) - (CW + 1)'(count_q);
		if (oldest_w >= (CW + 1)'(RECORD_DEPTH)) begin
			oldest_w = oldest_w - (CW + 1)'(RECORD_DEPTH);
		end
		oldest = oldest_w[HW-1:0];
	end

	assign page_we = ctl.clr_step | ctl.stamp_step;
	assign page_wa = ctl.clr_step ? clr_q : p_q;
	assign page_wd = ctl.clr_step ? '0 : epoch_q;

	// Newer than the stamp and overlapping the range, or the oldest record shows overflow.
	assign rec_hit = ((rec_rd_s1.rev > sep_q) &&
			(start_q <= rec_rd_s1.last) && (rec_rd_s1.first <= last_q)) ||
		(rfirst_s1 && (rec_rd_s1.rev > RW'(1)) && (sep_q < rec_rd_s1.rev - RW'(1)));

	always_ff @(posedge clk) begin
		if (page_we) begin
			page_mem[page_wa] <= page_wd;
		end
		page_rd_s1 <= page_mem[p_q];
		if (ctl.log_write) begin
			rec_mem[head_q] <= '{rev: epoch_q + RW'(1), first: start_q, last: last_q};
		end
		rec_rd_s1 <= rec_mem[k_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q   <= RW'(1);
			head_q    <= '0;
			count_q   <= '0;
			clr_q     <= '0;
			pacc_s1   <= 1'b0;
			racc_s1   <= 1'b0;
			rfirst_s1 <= 1'b0;
		end else begin
			pacc_s1   <= ctl.pscan_step;
			racc_s1   <= ctl.rscan_step;
			rfirst_s1 <= ctl.rscan_step && (i_q == '0);
			if (ctl.clr_step) begin
				clr_q <= clr_q + PW'(1);
			end
			if (ctl.log_write) begin
				epoch_q <= epoch_q + RW'(1);
				head_q  <= (head_q == HW'(RECORD_DEPTH - 1)) ? '0 : head_q + HW'(1);
				if (count_q != CW'(RECORD_DEPTH)) begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			code_q    <= mrct_pkg::cmd_code_t'(cmd);
			invalid_q <= (in_start == '0) || (in_bytes == '0);
			start_q   <= in_start;
			last_q    <= in_last;
			p_q       <= in_start[ADDR_BITS-1:PAGE_SHIFT];
			lp_q      <= in_last[ADDR_BITS-1:PAGE_SHIFT];
			srev_q    <= stamp_page_revision;
			sep_q     <= stamp_write_epoch;
			acc_q     <= '0;
			hit_q     <= 1'b0;
		end else begin
			if (ctl.stamp_step || ctl.pscan_step) begin
				p_q <= p_q + PW'(1);
			end
			if (pacc_s1 && (page_rd_s1 > acc_q)) begin
				acc_q <= page_rd_s1;
			end
			if (ctl.rscan_start) begin
				k_q <= oldest;
				i_q <= '0;
			end else if (ctl.rscan_step) begin
				k_q <= (k_q == HW'(RECORD_DEPTH - 1)) ? '0 : k_q + HW'(1);
				i_q <= i_q + CW'(1);
			end
			if (racc_s1 && rec_hit) begin
				hit_q <= 1'b1;
			end
		end
		if (ctl.out_load) begin
			changed       <= 1'b0;
			page_revision <= acc_q;
			write_epoch   <= epoch_q;
			if (invalid_q) begin
				page_revision <= (code_q == mrct_pkg::CMD_CHECK) ? srev_q : '0;
				write_epoch   <= (code_q == mrct_pkg::CMD_CHECK) ? sep_q : '0;
			end else if (code_q == mrct_pkg::CMD_QUERY) begin
				write_epoch <= '0;
			end else if (code_q == mrct_pkg::CMD_CHECK) begin
				if (acc_q == srev_q) begin
					page_revision <= srev_q;
				end else if (hit_q) begin
					changed       <= 1'b1;
					page_revision <= srev_q;
					write_epoch   <= sep_q;
				end
			end
		end
	end

	assign stat.code       = code_q;
	assign stat.invalid    = invalid_q;
	assign stat.clr_last   = (clr_q == PW'(PAGES - 1));
	assign stat.page_last  = (p_q == lp_q);
	assign stat.rec_last   = (i_q == count_q - CW'(1));
	assign stat.rev_match  = (acc_q == srev_q);
	assign stat.count_zero = (count_q == '0);

endmodule

// ----- hw/rtl/mrct_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the range change tracker.
// Sequences the clearing pass, page walks and record scans. Uses mrct_pkg.
module mrct_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output mrct_pkg::ctl_cmd_t ctl,
	input  mrct_pkg::dp_stat_t stat
);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_CALC, ST_STAMP, ST_PSCAN,
		ST_PDRAIN, ST_EVAL, ST_RSCAN, ST_RDRAIN, ST_RESULT
	} state_t;

	state_t state_q;
	logic   out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid || out_ready;

	always_comb begin
		ctl = '0;
		ctl.load = in_valid && in_ready;
		case (state_q)
			ST_CLEAR:  ctl.clr_step = 1'b1;
			ST_CALC:   ctl.log_write = !stat.invalid && (stat.code == mrct_pkg::CMD_WRITE);
			ST_STAMP:  ctl.stamp_step = 1'b1;
			ST_PSCAN:  ctl.pscan_step = 1'b1;
			ST_EVAL:   ctl.rscan_start = 1'b1;
			ST_RSCAN:  ctl.rscan_step = 1'b1;
			ST_RESULT: ctl.out_load = out_free;
			default:   ctl.load = in_valid && in_ready;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			out_valid <= 1'b0;
		end else begin
			if (ctl.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (stat.clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (ctl.load) state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (stat.invalid) begin
						state_q <= (stat.code == mrct_pkg::CMD_WRITE) ? ST_IDLE : ST_RESULT;
					end else if (stat.code == mrct_pkg::CMD_WRITE) begin
						state_q <= ST_STAMP;
					end else begin
						state_q <= ST_PSCAN;
					end
				end
				ST_STAMP: begin
					if (stat.page_last) state_q <= ST_IDLE;
				end
				ST_PSCAN: begin
					if (stat.page_last) state_q <= ST_PDRAIN;
				end
				ST_PDRAIN: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (stat.code != mrct_pkg::CMD_CHECK || stat.rev_match || stat.count_zero) begin
						state_q <= ST_RESULT;
					end else begin
						state_q <= ST_RSCAN;
					end
				end
				ST_RSCAN: begin
					if (stat.rec_last) state_q <= ST_RDRAIN;
				end
				ST_RDRAIN: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for memory_range_change_tracker: directed words, then random ones.
// Needs mrct_pkg and the tracker RTL; every result word is compared with an in-bench model or a row's typed result.
module tb;

	localparam longint unsigned TOP_ADDR = 64'hFFFF_FFFF;
	localparam int RING_DEPTH = 4096;
	localparam int RANDOM_WORDS = 120;
	// Room for the clearing pass, the whole-space walks and plenty of slack.
	localparam int CYCLE_LIMIT = 3_000_000;

	typedef struct packed {
		logic        changed;
		logic [63:0] page_revision;
		logic [63:0] write_epoch;
	} result_t;

	typedef struct {
		mrct_pkg::cmd_code_t op;
		logic [31:0]         addr;
		logic [31:0]         len;
		logic [63:0]         srev;
		logic [63:0]         sepoch;
		bit                  typed;
		result_t             res;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] cmd = mrct_pkg::CMD_QUERY;
	logic [31:0] address = 0;
	logic [31:0] byte_count = 0;
	logic [63:0] stamp_page_revision = 0;
	logic [63:0] stamp_write_epoch = 0;
	logic out_valid;
	logic out_ready = 0;
	logic changed;
	logic [63:0] page_revision;
	logic [63:0] write_epoch;

	memory_range_change_tracker dut (.*);

	always #4 clk = ~clk;

	// Model state: the page revisions live in a sparse array, so untouched pages read as zero.
	logic [63:0] page_rev [int unsigned];
	logic [63:0] log_rev [RING_DEPTH];
	longint unsigned log_first [RING_DEPTH];
	longint unsigned log_last [RING_DEPTH];
	int unsigned log_head = 0;
	int unsigned log_count = 0;
	logic [63:0] epoch = 1;

	result_t pending_results [$];
	int fail_count = 0;
	int cycle_count = 0;
	int max_gap = 7;
	bit result_taken = 0;
	int stall_left = 0;

	function automatic longint unsigned range_end(longint unsigned first, longint unsigned len);
		if (len - 1 > TOP_ADDR - first)
			return TOP_ADDR;
		return first + len - 1;
	endfunction

	function automatic logic [63:0] newest_revision(longint unsigned first, longint unsigned last);
		logic [63:0] best;
		best = 0;
		for (longint unsigned p = first >> 16; p <= (last >> 16); p++)
			if (page_rev.exists(p) && page_rev[p] > best)
				best = page_rev[p];
		return best;
	endfunction

	// Advances the model by one accepted word and returns whether a result word follows.
	function automatic bit track_word(input row_t w, output result_t r);
		longint unsigned first, last;
		logic [63:0] rev;
		int unsigned oldest, k;
		bit hit;
		first = w.addr;
		r = '0;
		if (w.addr == 0 || w.len == 0) begin
			if (w.op == mrct_pkg::CMD_WRITE)
				return 0;
			if (w.op == mrct_pkg::CMD_CHECK) begin
				r.page_revision = w.srev;
				r.write_epoch = w.sepoch;
			end
			return 1;
		end
		last = range_end(first, w.len);
		if (w.op == mrct_pkg::CMD_WRITE) begin
			epoch = epoch + 1;
			log_rev[log_head] = epoch;
			log_first[log_head] = first;
			log_last[log_head] = last;
			log_head = (log_head + 1) % RING_DEPTH;
			if (log_count < RING_DEPTH)
				log_count++;
			for (longint unsigned p = first >> 16; p <= (last >> 16); p++)
				page_rev[p] = epoch;
			return 0;
		end
		rev = newest_revision(first, last);
		r.page_revision = rev;
		if (w.op == mrct_pkg::CMD_QUERY)
			return 1;
		r.write_epoch = epoch;
		if (w.op == mrct_pkg::CMD_STAMP || rev == w.srev) begin
			if (w.op == mrct_pkg::CMD_CHECK)
				r.page_revision = w.srev;
			return 1;
		end
		if (log_count != 0) begin
			oldest = (log_head + RING_DEPTH - log_count) % RING_DEPTH;
			// History that no longer reaches back to the caller's epoch counts as a change.
			hit = log_rev[oldest] > 1 && w.sepoch < log_rev[oldest] - 1;
			for (int unsigned i = 0; !hit && i < log_count; i++) begin
				k = (oldest + i) % RING_DEPTH;
				if (log_rev[k] > w.sepoch && first <= log_last[k] && log_first[k] <= last)
					hit = 1;
			end
			if (hit) begin
				r.changed = 1;
				r.page_revision = w.srev;
				r.write_epoch = w.sepoch;
			end
		end
		return 1;
	endfunction

	// Drives one word after a random gap and holds it until the tracker takes it.
	task automatic send_word(input row_t w);
		result_t r;
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1;
		cmd = w.op;
		address = w.addr;
		byte_count = w.len;
		stamp_page_revision = w.srev;
		stamp_write_epoch = w.sepoch;
		do @(posedge clk); while (!in_ready);
		if (track_word(w, r))
			pending_results.push_back(w.typed ? w.res : r);
		@(negedge clk);
	endtask

	// Result side: a random stall is drawn for every word that leaves the tracker.
	always @(negedge clk) begin
		if (result_taken) begin
			result_taken = 0;
			stall_left = $urandom_range(0, max_gap);
		end
		if (stall_left > 0) begin
			out_ready = 0;
			stall_left--;
		end else begin
			out_ready = 1;
		end
	end

	always @(posedge clk) begin
		result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			result_taken = 1;
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (changed !== want.changed) begin
					$error("changed: expected %0d, got %0d", want.changed, changed);
					fail_count++;
				end
				if (page_revision !== want.page_revision) begin
					$error("page_revision: expected %0h, got %0h",
						want.page_revision, page_revision);
					fail_count++;
				end
				if (write_epoch !== want.write_epoch) begin
					$error("write_epoch: expected %0h, got %0h", want.write_epoch, write_epoch);
					fail_count++;
				end
			end
		end
	end

	// Random ranges mostly sit in the first sixteen pages so that writes and checks overlap.
	function automatic row_t random_word();
		row_t w;
		int pick;
		w.typed = 0;
		w.res = '0;
		w.op = mrct_pkg::cmd_code_t'($urandom_range(0, 3));
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			w.addr = ($urandom_range(0, 15) << 16) | $urandom_range(0, 16'hFFFF);
			w.len = $urandom_range(1, 32'h3_0000);
		end else if (pick < 88) begin
			// Near the top with any length: the end saturates, so few pages are walked.
			w.addr = 32'hFFF0_0000 | $urandom_range(0, 20'hF_FFFF);
			w.len = $urandom();
		end else if (pick < 95) begin
			w.addr = $urandom();
			w.len = $urandom_range(1, 32'hFFFF);
		end else begin
			w.addr = ($urandom_range(0, 1) == 0) ? 0 : $urandom();
			w.len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 255);
		end
		// Stamps: mostly the honest current revision, sometimes stale or arbitrary.
		w.srev = newest_revision(w.addr, range_end(w.addr, w.len == 0 ? 1 : w.len));
		w.sepoch = epoch - $urandom_range(0, 6);
		pick = $urandom_range(0, 9);
		if (pick < 3)
			w.srev = {$urandom(), $urandom()};
		else if (pick < 5)
			w.srev = w.srev - 1;
		if ($urandom_range(0, 9) < 2)
			w.sepoch = {$urandom(), $urandom()};
		else if ($urandom_range(0, 19) == 0)
			w.sepoch = 0;
		return w;
	endfunction

	row_t directed [] = '{
		// Fresh tracker: nothing written, epoch one.
		'{mrct_pkg::CMD_QUERY, 32'd1, 32'd1, 64'd0, 64'd0, 1, '{1'b0, 64'd0, 64'd0}},
		'{mrct_pkg::CMD_STAMP, 32'd1, 32'd1, 64'd0, 64'd0, 1, '{1'b0, 64'd0, 64'd1}},
		'{mrct_pkg::CMD_CHECK, 32'h1_0000, 32'h100, 64'd0, 64'd5, 1, '{1'b0, 64'd0, 64'd1}},
		// Zero address or zero length is a no-op: zero results, but a check echoes the caller's stamp.
		'{mrct_pkg::CMD_WRITE, 32'd0, 32'd5, 64'd0, 64'd0, 0, '0},
		'{mrct_pkg::CMD_QUERY, 32'd0, 32'd5, 64'd0, 64'd0, 1, '{1'b0, 64'd0, 64'd0}},
		'{mrct_pkg::CMD_STAMP, 32'd7, 32'd0, 64'd0, 64'd0, 1, '{1'b0, 64'd0, 64'd0}},
		'{mrct_pkg::CMD_CHECK, 32'd0, 32'd0, '1, 64'h5555_5555_5555_5555, 1,
			'{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555}},
		'{mrct_pkg::CMD_WRITE, 32'h1_0000, 32'h10, 64'd0, 64'd0, 0, '0},
		'{mrct_pkg::CMD_QUERY, 32'h1_0000, 32'd1, 64'd0, 64'd0, 0, '0},
		'{mrct_pkg::CMD_CHECK, 32'h1_0000, 32'd1, 64'd0, 64'd1, 0, '0},
		// An epoch of zero lies before the oldest record: the history has overflowed.
		'{mrct_pkg::CMD_CHECK, 32'h2_0000, 32'd1, 64'd9, 64'd0, 0, '0},
		'{mrct_pkg::CMD_CHECK, 32'h2_0000, 32'd1, 64'd9, 64'd2, 0, '0},
		// Saturation at the top address.
		'{mrct_pkg::CMD_WRITE, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 64'd0, 64'd0, 0, '0},
		'{mrct_pkg::CMD_QUERY, 32'hFFFF_FFFF, 32'd1, 64'd0, 64'd0, 0, '0},
		'{mrct_pkg::CMD_STAMP, 32'hFFFF_0000, 32'hFFFF_FFFF, 64'd0, 64'd0, 0, '0},
		// Whole address space, every page walked.
		'{mrct_pkg::CMD_WRITE, 32'd1, 32'hFFFF_FFFF, 64'd0, 64'd0, 0, '0},
		'{mrct_pkg::CMD_QUERY, 32'd1, 32'hFFFF_FFFF, 64'd0, 64'd0, 0, '0},
		'{mrct_pkg::CMD_WRITE, 32'h5_0000, 32'h2_0000, 64'd0, 64'd0, 0, '0},
		'{mrct_pkg::CMD_CHECK, 32'h7_0000, 32'd1, 64'd3, 64'd4, 0, '0},
		'{mrct_pkg::CMD_CHECK, 32'h5_8000, 32'h1_0000, 64'd3, 64'd4, 0, '0},
		'{mrct_pkg::CMD_CHECK, 32'h5_8000, 32'h1_0000, 64'd5, 64'd5, 0, '0}
	};

	initial begin
		int words;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		foreach (directed[i])
			send_word(directed[i]);
		words = 0;
		while (words < RANDOM_WORDS) begin
			// Every 35 words the bench alternates between full-speed and idling stretches.
			if (words % 35 == 0)
				max_gap = (max_gap == 0) ? 7 : 0;
			send_word(random_word());
			words++;
		end
		in_valid = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule

// ----- files.f -----
hw/rtl/mrct_pkg.sv
hw/rtl/mrct_datapath.sv
hw/rtl/mrct_ctrl.sv
hw/rtl/memory_range_change_tracker.sv
test/tb.sv
